[hdl/unit_ball_projection_3d_unit_defines.svh]
// Assertion macros for the unit ball projection block.
`ifndef UNIT_BALL_PROJECTION_3D_UNIT_DEFINES_SVH
`define UNIT_BALL_PROJECTION_3D_UNIT_DEFINES_SVH
`ifndef SYNTH
`define UBP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UBP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UBP_ASSERT_IMP(lbl, ante, cons)
`define UBP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/ubp_pkg.sv]
// Shared widths, constants and sideband types for the unit ball projection block.
package ubp_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int SW      = 2 * DATA_WIDTH;
  localparam int QW      = DATA_WIDTH + 2;
  localparam int NUMW    = DATA_WIDTH + FRAC_BITS + 2;
  localparam int DOTW    = DATA_WIDTH + FRAC_BITS + 2;
  localparam int PRW     = 2 * QW;
  localparam int SQ_LAT  = DATA_WIDTH;
  localparam int DIV_LAT = QW + 2;
  localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

  typedef struct packed {
    logic                             mode;
    logic [2:0][DATA_WIDTH-1:0]       vec;
    logic [2:0][DATA_WIDTH-1:0]       grad;
  } sq_side_t;

  typedef struct packed {
    logic                             mode;
    logic                             clip;
    logic [DATA_WIDTH-1:0]            nrm;
    logic [DATA_WIDTH-1:0]            p;
    logic [2:0][DATA_WIDTH-1:0]       grad;
  } d1_side_t;

  typedef struct packed {
    logic                             mode;
    logic                             clip;
    logic [DATA_WIDTH-1:0]            nrm;
    logic [2:0][QW-1:0]               y;
    logic [2:0][QW-1:0]               gp;
  } d2_side_t;
endpackage

[hdl/unit_ball_projection_3d_unit.sv]
// Top level: projection of a 3-vector onto the unit ball, forward and gradient.
// Throughput: one item per cycle while the output is not stalled; the sqrt
// stages and two chained dividers each produce one bit per stage.
// A stalled output freezes the whole pipeline.
// Reset clears the valid bits only; the data registers are not reset.
module unit_ball_projection_3d_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_mode,
  input  logic signed [ubp_pkg::DATA_WIDTH-1:0]  in_vec_x,
  input  logic signed [ubp_pkg::DATA_WIDTH-1:0]  in_vec_y,
  input  logic signed [ubp_pkg::DATA_WIDTH-1:0]  in_vec_z,
  input  logic signed [ubp_pkg::DATA_WIDTH-1:0]  in_grad_x,
  input  logic signed [ubp_pkg::DATA_WIDTH-1:0]  in_grad_y,
  input  logic signed [ubp_pkg::DATA_WIDTH-1:0]  in_grad_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ubp_pkg::DATA_WIDTH-1:0]  out_res_x,
  output logic signed [ubp_pkg::DATA_WIDTH-1:0]  out_res_y,
  output logic signed [ubp_pkg::DATA_WIDTH-1:0]  out_res_z,
  output logic [ubp_pkg::DATA_WIDTH-1:0]         out_norm_value,
  output logic                                   out_clipped,
  output logic                                   out_saturated
);
  import ubp_pkg::*;
  `include "unit_ball_projection_3d_unit_defines.svh"

  localparam int W = DATA_WIDTH;
  localparam logic signed [QW-1:0] SAT_HI = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [PRW-1:0] HALF = PRW'(1) << (FRAC_BITS - 1);

  logic adv;

  // stage a: input capture
  logic a_v_r;
  sq_side_t a_side_r;
  // stage b: squares
  logic b_v_r;
  logic [SW-1:0] b_sq_r [3];
  sq_side_t b_side_r;
  // stage c: sum of squares
  logic c_v_r;
  logic [SW-1:0] c_sum_r;
  sq_side_t c_side_r;
  // sqrt pipeline sideband
  logic [SQ_LAT-1:0] sq_v_r;
  sq_side_t sq_side_r [SQ_LAT];
  logic [W-1:0] nrm;
  // stage e: divisor and magnitudes
  logic e_v_r;
  d1_side_t e_side_r;
  logic [W-1:0] e_vabs_r [3];
  logic [W-1:0] e_gabs_r [3];
  logic [2:0] e_vneg_r;
  logic [2:0] e_gneg_r;
  // first divider sideband
  logic [DIV_LAT-1:0] d1_v_r;
  d1_side_t d1_side_r [DIV_LAT];
  logic signed [QW-1:0] yq [3];
  logic signed [QW-1:0] gq [3];
  // stage f: g*y
  logic f_v_r;
  d1_side_t f_side_r;
  logic signed [DOTW-1:0] f_prod_r [3];
  logic [2:0][QW-1:0] f_y_r;
  logic [2:0][QW-1:0] f_gp_r;
  // stage h: dot
  logic h_v_r;
  d1_side_t h_side_r;
  logic signed [DOTW-1:0] h_dot_r;
  logic [2:0][QW-1:0] h_y_r;
  logic [2:0][QW-1:0] h_gp_r;
  logic [DOTW-1:0] dot_abs;
  // second divider sideband
  logic [DIV_LAT-1:0] d2_v_r;
  d2_side_t d2_side_nxt;
  d2_side_t d2_side_r [DIV_LAT];
  logic signed [QW-1:0] dq;
  // stage k: d*y
  logic k_v_r;
  d2_side_t k_side_r;
  logic signed [PRW-1:0] k_dy_r [3];
  // stage m: corrected gradient
  logic m_v_r;
  d2_side_t m_side_r;
  logic signed [QW-1:0] m_r_r [3];
  // stage o: output
  logic o_v_r;
  logic [2:0][W-1:0] o_res_r;
  logic [W-1:0] o_nrm_r;
  logic o_clip_r;
  logic o_sat_r;

  assign adv      = !(o_v_r && out_stall);
  assign in_stall = !adv;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      sq_v_r <= '0;
      e_v_r  <= 1'b0;
      d1_v_r <= '0;
      f_v_r  <= 1'b0;
      h_v_r  <= 1'b0;
      d2_v_r <= '0;
      k_v_r  <= 1'b0;
      m_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      a_v_r  <= in_valid;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      sq_v_r <= {sq_v_r[SQ_LAT-2:0], c_v_r};
      e_v_r  <= sq_v_r[SQ_LAT-1];
      d1_v_r <= {d1_v_r[DIV_LAT-2:0], e_v_r};
      f_v_r  <= d1_v_r[DIV_LAT-1];
      h_v_r  <= f_v_r;
      d2_v_r <= {d2_v_r[DIV_LAT-2:0], h_v_r};
      k_v_r  <= d2_v_r[DIV_LAT-1];
      m_v_r  <= k_v_r;
      o_v_r  <= m_v_r;
    end
  end

  // stages a to c
  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r.mode <= in_mode;
      a_side_r.vec  <= {in_vec_z, in_vec_y, in_vec_x};
      a_side_r.grad <= {in_grad_z, in_grad_y, in_grad_x};
      for (int t = 0; t < 3; t++) begin
        b_sq_r[t] <= SW'(SW'($signed(a_side_r.vec[t])) * SW'($signed(a_side_r.vec[t])));
      end
      b_side_r <= a_side_r;
      c_sum_r  <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      c_side_r <= b_side_r;
      sq_side_r[0] <= c_side_r;
      for (int i = 1; i < SQ_LAT; i++) sq_side_r[i] <= sq_side_r[i-1];
    end
  end

  ubp_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .x_in     (c_sum_r),
    .root_out (nrm)
  );

  // stage e
  always_ff @(posedge clk) begin
    if (adv) begin
      e_side_r.mode <= sq_side_r[SQ_LAT-1].mode;
      e_side_r.clip <= nrm > ONE;
      e_side_r.nrm  <= nrm;
      e_side_r.p    <= (nrm > ONE) ? nrm : ONE;
      e_side_r.grad <= sq_side_r[SQ_LAT-1].grad;
      for (int t = 0; t < 3; t++) begin
        e_vneg_r[t] <= sq_side_r[SQ_LAT-1].vec[t][W-1];
        e_gneg_r[t] <= sq_side_r[SQ_LAT-1].grad[t][W-1];
        e_vabs_r[t] <= sq_side_r[SQ_LAT-1].vec[t][W-1] ?
                       (~sq_side_r[SQ_LAT-1].vec[t] + W'(1)) : sq_side_r[SQ_LAT-1].vec[t];
        e_gabs_r[t] <= sq_side_r[SQ_LAT-1].grad[t][W-1] ?
                       (~sq_side_r[SQ_LAT-1].grad[t] + W'(1)) : sq_side_r[SQ_LAT-1].grad[t];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_div1
      ubp_div u_ydiv (
        .clk    (clk),
        .en     (adv),
        .neg_in (e_vneg_r[g]),
        .num_in ((NUMW'(e_vabs_r[g]) << FRAC_BITS) + NUMW'(e_side_r.p >> 1)),
        .den_in (e_side_r.p),
        .q_out  (yq[g])
      );
      ubp_div u_gdiv (
        .clk    (clk),
        .en     (adv),
        .neg_in (e_gneg_r[g]),
        .num_in ((NUMW'(e_gabs_r[g]) << FRAC_BITS) + NUMW'(e_side_r.p >> 1)),
        .den_in (e_side_r.p),
        .q_out  (gq[g])
      );
    end
  endgenerate

  // stages f and h
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_side_r[0] <= e_side_r;
      for (int i = 1; i < DIV_LAT; i++) d1_side_r[i] <= d1_side_r[i-1];
      f_side_r <= d1_side_r[DIV_LAT-1];
      for (int t = 0; t < 3; t++) begin
        f_prod_r[t] <= DOTW'((W+QW)'($signed(d1_side_r[DIV_LAT-1].grad[t])) *
                             (W+QW)'(yq[t]));
        f_y_r[t]    <= yq[t];
        f_gp_r[t]   <= gq[t];
      end
      h_side_r <= f_side_r;
      h_dot_r  <= f_prod_r[0] + f_prod_r[1] + f_prod_r[2];
      h_y_r    <= f_y_r;
      h_gp_r   <= f_gp_r;
    end
  end

  assign dot_abs = h_dot_r[DOTW-1] ? DOTW'(-h_dot_r) : DOTW'(h_dot_r);

  ubp_div u_ddiv (
    .clk    (clk),
    .en     (adv),
    .neg_in (h_dot_r > 0),
    .num_in (NUMW'(dot_abs) + NUMW'(h_side_r.p >> 1)),
    .den_in (h_side_r.p),
    .q_out  (dq)
  );

  always_comb begin
    d2_side_nxt.mode = h_side_r.mode;
    d2_side_nxt.clip = h_side_r.clip;
    d2_side_nxt.nrm  = h_side_r.nrm;
    d2_side_nxt.y    = h_y_r;
    d2_side_nxt.gp   = h_gp_r;
  end

  // stages k, m, o
  always_ff @(posedge clk) begin
    logic signed [PRW-1:0] dsel;
    logic [PRW-1:0]        dabs;
    logic [PRW-1:0]        rmag;
    logic signed [QW-1:0]  rnd;
    logic signed [QW-1:0]  sel;
    logic                  sat;
    if (adv) begin
      d2_side_r[0] <= d2_side_nxt;
      for (int i = 1; i < DIV_LAT; i++) d2_side_r[i] <= d2_side_r[i-1];
      k_side_r <= d2_side_r[DIV_LAT-1];
      dsel = d2_side_r[DIV_LAT-1].clip ? PRW'(dq) : '0;
      for (int t = 0; t < 3; t++) begin
        k_dy_r[t] <= dsel * PRW'($signed(d2_side_r[DIV_LAT-1].y[t]));
      end
      m_side_r <= k_side_r;
      for (int t = 0; t < 3; t++) begin
        dabs = k_dy_r[t][PRW-1] ? PRW'(-k_dy_r[t]) : PRW'(k_dy_r[t]);
        rmag = (dabs + HALF) >> FRAC_BITS;
        rnd  = k_dy_r[t][PRW-1] ? -$signed(rmag[QW-1:0]) : $signed(rmag[QW-1:0]);
        m_r_r[t] <= $signed(k_side_r.gp[t]) + rnd;
      end
      sat = 1'b0;
      for (int t = 0; t < 3; t++) begin
        sel = m_side_r.mode ? m_r_r[t] : $signed(m_side_r.y[t]);
        if (sel > SAT_HI) begin
          o_res_r[t] <= SAT_HI[W-1:0];
          sat = 1'b1;
        end else if (sel < SAT_LO) begin
          o_res_r[t] <= SAT_LO[W-1:0];
          sat = 1'b1;
        end else begin
          o_res_r[t] <= sel[W-1:0];
        end
      end
      o_sat_r  <= sat;
      o_nrm_r  <= m_side_r.nrm;
      o_clip_r <= m_side_r.clip;
    end
  end

  assign out_valid      = o_v_r;
  assign out_res_x      = o_res_r[0];
  assign out_res_y      = o_res_r[1];
  assign out_res_z      = o_res_r[2];
  assign out_norm_value = o_nrm_r;
  assign out_clipped    = o_clip_r;
  assign out_saturated  = o_sat_r;

  `UBP_ASSERT_IMP(a_noclip_zero_corr, k_v_r && !k_side_r.clip, k_dy_r[0] == '0)
  `UBP_ASSERT_IMP(a_clip_matches_norm, o_v_r, o_clip_r == (o_nrm_r > ONE))
  `UBP_ASSERT_NXT(a_stall_freezes, o_v_r && out_stall, $stable(h_dot_r) && $stable(c_sum_r))
endmodule

[hdl/ubp_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module ubp_sqrt (
  input  logic                                clk,
  input  logic                                en,
  input  logic [ubp_pkg::SW-1:0]              x_in,
  output logic [ubp_pkg::DATA_WIDTH-1:0]      root_out
);
  import ubp_pkg::*;

  logic [DATA_WIDTH+1:0] rem_r  [SQ_LAT];
  logic [DATA_WIDTH-1:0] root_r [SQ_LAT];
  logic [SW-1:0]         x_r    [SQ_LAT];

  genvar k;
  generate
    for (k = 0; k < SQ_LAT; k++) begin : g_stage
      logic [DATA_WIDTH+1:0] prem;
      logic [DATA_WIDTH-1:0] proot;
      logic [SW-1:0]         px;
      logic [DATA_WIDTH+1:0] rsh;
      logic [DATA_WIDTH+1:0] trial;
      if (k == 0) begin : g_first
        assign prem  = '0;
        assign proot = '0;
        assign px    = x_in;
      end else begin : g_next
        assign prem  = rem_r[k-1];
        assign proot = root_r[k-1];
        assign px    = x_r[k-1];
      end
      assign rsh   = {prem[DATA_WIDTH-1:0], px[SW-1 -: 2]};
      assign trial = {proot, 2'b01};
      always_ff @(posedge clk) begin
        if (en) begin
          if (rsh >= trial) begin
            rem_r[k]  <= rsh - trial;
            root_r[k] <= {proot[DATA_WIDTH-2:0], 1'b1};
          end else begin
            rem_r[k]  <= rsh;
            root_r[k] <= {proot[DATA_WIDTH-2:0], 1'b0};
          end
          x_r[k] <= px << 2;
        end
      end
    end
  endgenerate

  assign root_out = root_r[SQ_LAT-1];
endmodule

[hdl/ubp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, signed result.
module ubp_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                neg_in,
  input  logic [ubp_pkg::NUMW-1:0]            num_in,
  input  logic [ubp_pkg::DATA_WIDTH-1:0]      den_in,
  output logic signed [ubp_pkg::QW-1:0]       q_out
);
  import ubp_pkg::*;

  logic [DATA_WIDTH:0]   rem0_r;
  logic [QW-1:0]         low0_r;
  logic [DATA_WIDTH-1:0] den0_r;
  logic                  neg0_r;

  logic [DATA_WIDTH:0]   rem_r [QW];
  logic [QW-1:0]         low_r [QW];
  logic [DATA_WIDTH-1:0] den_r [QW];
  logic                  neg_r [QW];
  logic signed [QW-1:0]  q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= (DATA_WIDTH+1)'(num_in[NUMW-1:QW]);
      low0_r <= num_in[QW-1:0];
      den0_r <= den_in;
      neg0_r <= neg_in;
    end
  end

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [DATA_WIDTH:0]   prem;
      logic [QW-1:0]         plow;
      logic [DATA_WIDTH-1:0] pden;
      logic                  pneg;
      logic [DATA_WIDTH:0]   t;
      if (k == 0) begin : g_first
        assign prem = rem0_r;
        assign plow = low0_r;
        assign pden = den0_r;
        assign pneg = neg0_r;
      end else begin : g_next
        assign prem = rem_r[k-1];
        assign plow = low_r[k-1];
        assign pden = den_r[k-1];
        assign pneg = neg_r[k-1];
      end
      assign t = {prem[DATA_WIDTH-1:0], plow[QW-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (t >= {1'b0, pden}) begin
            rem_r[k] <= t - {1'b0, pden};
            low_r[k] <= {plow[QW-2:0], 1'b1};
          end else begin
            rem_r[k] <= t;
            low_r[k] <= {plow[QW-2:0], 1'b0};
          end
          den_r[k] <= pden;
          neg_r[k] <= pneg;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[QW-1] ? -$signed(low_r[QW-1]) : $signed(low_r[QW-1]);
    end
  end

  assign q_out = q_r;
endmodule
